// ===== rtl/sha256_hash_engine_core_macros.svh =====
// Assertion macros for the SHA-256 hash engine core.
// Included by the top level; expands to nothing when SYNTH is defined.
`ifndef SHA256_HASH_ENGINE_CORE_MACROS_SVH
`define SHA256_HASH_ENGINE_CORE_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising clock edge outside reset.
`define SHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHA_ASSERT(lbl, prop, msg)
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/sha256_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 hash engine.
// No dependencies; imported by every module of the core.
`default_nettype none

package sha256_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  // First fill level that no longer leaves room for the length in the same block.
  localparam logic [5:0] PAD_LIMIT = 6'd56;

  // Block handed from the front to the back.
  typedef struct packed {
    logic                             last_blk;
    logic [BlockWords-1:0][31:0]      words;
  } blk_item_t;

  // Initial chain value, h0 in element 0.
  localparam logic [7:0][31:0] INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha256_front.sv =====
// Front end of the SHA-256 core: packs bytes into a block, counts the message
// and builds the padding blocks. Depends on sha256_pkg.
`default_nettype none

module sha256_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [7:0]            s_axis_tdata_i,
  input  wire logic                  s_axis_tuser_i,
  input  wire logic                  s_axis_tlast_i,
  output logic                       push_valid_o,
  input  wire logic                  push_ready_i,
  output sha256_pkg::blk_item_t      push_item_o
);
  import sha256_pkg::*;

  typedef enum logic [1:0] {
    F_BYTES,
    F_PAD,
    F_LEN
  } front_state_e;

  front_state_e                state_q, state_d;
  logic [BlockWords-1:0][31:0] blk_q, blk_d, pad_blk;
  logic [5:0]                  fill_q, fill_d;
  logic                        full_q, full_d;
  logic                        lastblk_q, lastblk_d;
  logic [60:0]                 msg_q, msg_d;
  logic [63:0]                 bit_len;
  logic                        in_xfer;

  assign s_axis_tready_o = (state_q == F_BYTES) && !full_q;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign push_valid_o    = full_q;
  assign push_item_o     = '{last_blk: lastblk_q, words: blk_q};
  assign bit_len         = {msg_q, 3'b000};

  // 0x80 after the held bytes, zeros behind it.
  always_comb begin
    for (int i = 0; i < BlockWords; i++) begin
      for (int j = 0; j < 4; j++) begin
        if ((4'(i) < fill_q[5:2]) || ((4'(i) == fill_q[5:2]) && (2'(j) < fill_q[1:0]))) begin
          pad_blk[i][8*(3-j) +: 8] = blk_q[i][8*(3-j) +: 8];
        end else if ((4'(i) == fill_q[5:2]) && (2'(j) == fill_q[1:0])) begin
          pad_blk[i][8*(3-j) +: 8] = PAD_BYTE;
        end else begin
          pad_blk[i][8*(3-j) +: 8] = 8'h00;
        end
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    blk_d     = blk_q;
    fill_d    = fill_q;
    full_d    = full_q;
    lastblk_d = lastblk_q;
    msg_d     = msg_q;
    if (full_q && push_ready_i) begin
      full_d = 1'b0;
    end
    unique case (state_q)
      F_BYTES: begin
        if (in_xfer) begin
          if (s_axis_tuser_i) begin
            blk_d[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] = s_axis_tdata_i;
            fill_d = fill_q + 6'd1;
            msg_d  = msg_q + 61'd1;
            if (fill_q == 6'd63) begin
              full_d    = 1'b1;
              lastblk_d = 1'b0;
            end
          end
          if (s_axis_tlast_i) begin
            state_d = F_PAD;
          end
        end
      end
      F_PAD: begin
        if (!full_q) begin
          blk_d  = pad_blk;
          full_d = 1'b1;
          fill_d = '0;
          if (fill_q < PAD_LIMIT) begin
            blk_d[14] = bit_len[63:32];
            blk_d[15] = bit_len[31:0];
            lastblk_d = 1'b1;
            msg_d     = '0;
            state_d   = F_BYTES;
          end else begin
            lastblk_d = 1'b0;
            state_d   = F_LEN;
          end
        end
      end
      F_LEN: begin
        if (!full_q) begin
          blk_d     = '0;
          blk_d[14] = bit_len[63:32];
          blk_d[15] = bit_len[31:0];
          full_d    = 1'b1;
          lastblk_d = 1'b1;
          msg_d     = '0;
          state_d   = F_BYTES;
        end
      end
      default: state_d = F_BYTES;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_BYTES;
      fill_q    <= '0;
      full_q    <= 1'b0;
      lastblk_q <= 1'b0;
      msg_q     <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      full_q    <= full_d;
      lastblk_q <= lastblk_d;
      msg_q     <= msg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

endmodule

`default_nettype wire

// ===== rtl/sha256_queue.sv =====
// Two-entry block queue between the SHA-256 front and back.
// Depends on sha256_pkg for the block item type.
`default_nettype none

module sha256_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_valid_i,
  output logic                       push_ready_o,
  input  wire sha256_pkg::blk_item_t push_item_i,
  output logic                       pop_valid_o,
  input  wire logic                  pop_ready_i,
  output sha256_pkg::blk_item_t      pop_item_o
);
  import sha256_pkg::*;

  blk_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha256_back.sv =====
// Back end of the SHA-256 core: one round per cycle with a rolling message
// schedule, chain update and digest output register. Depends on sha256_pkg.
`default_nettype none

module sha256_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  pop_valid_i,
  output logic                       pop_ready_o,
  input  wire sha256_pkg::blk_item_t pop_item_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [39:0]                m_axis_tdata_o,
  output logic                       m_axis_tlast_o
);
  import sha256_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROUND,
    B_ADD
  } back_state_e;

  back_state_e                 state_q, state_d;
  logic [BlockWords-1:0][31:0] w_q, w_d;
  logic [7:0][31:0]            v_q, v_d;
  logic [7:0][31:0]            chain_q, chain_d, chain_sum;
  logic [7:0][31:0]            dig_q, dig_d;
  logic [5:0]                  rnd_q, rnd_d;
  logic                        fin_q, fin_d;
  logic [2:0]                  idx_q, idx_d;
  logic                        busy_q, busy_d;
  logic [31:0]                 t1, t2, w_next;
  logic                        out_xfer;

  assign pop_ready_o     = (state_q == B_IDLE);
  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = {5'b0, idx_q, dig_q[0]};
  assign m_axis_tlast_o  = (idx_q == 3'd7);
  assign out_xfer        = busy_q && m_axis_tready_i;

  always_comb begin
    t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + ROUND_K[rnd_q] + w_q[0];
    t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_next = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
    for (int i = 0; i < 8; i++) begin
      chain_sum[i] = chain_q[i] + v_q[i];
    end
  end

  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    v_d     = v_q;
    chain_d = chain_q;
    dig_d   = dig_q;
    rnd_d   = rnd_q;
    fin_d   = fin_q;
    idx_d   = idx_q;
    busy_d  = busy_q;
    // Shift the next digest word down on every output transfer.
    if (out_xfer) begin
      for (int i = 0; i < 7; i++) begin
        dig_d[i] = dig_q[i+1];
      end
      idx_d = idx_q + 3'd1;
      if (idx_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
    unique case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          w_d     = pop_item_i.words;
          v_d     = chain_q;
          fin_d   = pop_item_i.last_blk;
          rnd_d   = '0;
          state_d = B_ROUND;
        end
      end
      B_ROUND: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        for (int i = 0; i < BlockWords - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[BlockWords-1] = w_next;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(Rounds - 1)) begin
          state_d = B_ADD;
        end
      end
      B_ADD: begin
        if (!fin_q) begin
          chain_d = chain_sum;
          state_d = B_IDLE;
        end else if (!busy_q) begin
          // Hand the digest to the output register and restart the chain.
          dig_d   = chain_sum;
          chain_d = INIT_HASH;
          idx_d   = '0;
          busy_d  = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      chain_q <= INIT_HASH;
      rnd_q   <= '0;
      fin_q   <= 1'b0;
      idx_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      chain_q <= chain_d;
      rnd_q   <= rnd_d;
      fin_q   <= fin_d;
      idx_q   <= idx_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    v_q   <= v_d;
    dig_q <= dig_d;
  end

endmodule

`default_nettype wire

// ===== rtl/sha256_hash_engine_core.sv =====
// SHA-256 hash engine, top level. Message bytes enter on the slave stream one
// per transfer and are packed big-endian into a 64-byte block by the front
// end; a transfer with tlast set ends the message (tuser low marks it as
// carrying no byte, which allows an empty message). Full and padding blocks
// pass through a two-entry queue to the back end, which runs one compression
// round per cycle: it loads a block, runs 64 rounds and adds the result into
// the chain value before it takes the next block, and that single round unit
// sets the sustained rate. The front takes one byte per cycle while it collects
// bytes and its block register is not full, and holds a full block until the
// queue takes it; finishing a message takes one or two more blocks. The eight
// digest words then leave on the master stream, h0 first, one per cycle while
// tready is high, with tlast on the eighth; the chain value is already reset
// for the next message, whose bytes may arrive while the digest drains.
// Depends on sha256_pkg, sha256_front, sha256_queue, sha256_back and the
// assertion macros header.
`default_nettype none
`include "sha256_hash_engine_core_macros.svh"

module sha256_hash_engine_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] has_byte
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index
  output logic             m_axis_tlast_o    // last_word
);
  import sha256_pkg::*;

  // Front to queue.
  logic      push_valid, push_ready;
  blk_item_t push_item;
  // Queue to back.
  logic      pop_valid, pop_ready;
  blk_item_t pop_item;

  // Accept bytes, pad and frame blocks.
  sha256_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_item_o     (push_item)
  );

  // Decouple packing from compression.
  sha256_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Compress blocks and drain the digest.
  sha256_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_item_i      (pop_item),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // tlast marks exactly the eighth digest word.
  `SHA_ASSERT(a_last_on_word7, m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tdata_o[34:32] == 3'd7)), "tlast does not match word index")
  // Digest words follow each other without a gap and in order.
  `SHA_ASSERT_NEXT(a_words_in_order, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, m_axis_tvalid_o && (m_axis_tdata_o[34:32] == $past(m_axis_tdata_o[34:32]) + 3'd1), "digest words out of order")
  // A new digest never starts right behind the last word of the previous one.
  `SHA_ASSERT_NEXT(a_gap_after_digest, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, !m_axis_tvalid_o, "digest output overrun")

endmodule

`default_nettype wire
